>>> rtl/core/sppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo ping-pong delay package
// Widths, register codes, item types and the saturation helper shared by the
// delay unit.
// ----------------------------------------------------------------------------
package sppd_pkg;

   // sample and memory geometry
   localparam int SAMPLE_BITS = 24;
   localparam int ADDR_BITS   = 17;
   localparam int MAX_DELAY   = 1 << ADDR_BITS;
   localparam int LEVEL_BITS  = 32;
   localparam int TONE_GUARD  = LEVEL_BITS - SAMPLE_BITS;
   localparam int COEF_BITS   = 16;
   localparam int DELAY_BITS  = 17;

   // datapath widths
   localparam int DIFF_BITS  = LEVEL_BITS + 1;
   localparam int TPROD_BITS = DIFF_BITS + COEF_BITS + 1;
   localparam int STEP_BITS  = TPROD_BITS - COEF_BITS;
   localparam int WPROD_BITS = SAMPLE_BITS + COEF_BITS + 1;
   localparam int DPROD_BITS = SAMPLE_BITS + COEF_BITS + 2;
   localparam int MIX_BITS   = DPROD_BITS + 1;
   localparam int WIDE_BITS  = MIX_BITS - COEF_BITS;
   localparam int FPROD_BITS = LEVEL_BITS + COEF_BITS + 1;
   localparam int FB_SHIFT   = COEF_BITS + TONE_GUARD;
   localparam int FB_BITS    = FPROD_BITS - FB_SHIFT;

   // rounding offsets
   localparam logic signed [MIX_BITS-1:0]   MIX_ROUND = MIX_BITS'(1) << (COEF_BITS - 1);
   localparam logic signed [FPROD_BITS-1:0] FB_ROUND  = FPROD_BITS'(1) << (FB_SHIFT - 1);

   // saturation bounds in the wide domain
   localparam logic signed [WIDE_BITS-1:0] WIDE_HI =
      WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [WIDE_BITS-1:0] WIDE_LO = -WIDE_HI - WIDE_BITS'(1);

   // feedback gain ceiling, 0.95 in Q0.16
   localparam logic [COEF_BITS-1:0] GAIN_CAP = 16'd62259;

   // register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ENABLED       = 3'd0,
      CSR_MONO_MODE     = 3'd1,
      CSR_PING_PONG     = 3'd2,
      CSR_DELAY_LENGTH  = 3'd3,
      CSR_FEEDBACK_GAIN = 3'd4,
      CSR_WET_MIX       = 3'd5,
      CSR_TONE_ALPHA    = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic                  RST_ENABLED   = 1'b1;
   localparam logic                  RST_MONO_MODE = 1'b0;
   localparam logic                  RST_PING_PONG = 1'b1;
   localparam logic [DELAY_BITS-1:0] RST_DELAY     = 17'd21600;
   localparam logic [COEF_BITS-1:0]  RST_GAIN      = 16'd36045;
   localparam logic [COEF_BITS-1:0]  RST_WET       = 16'd22938;
   localparam logic [COEF_BITS-1:0]  RST_ALPHA     = 16'd22000;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_item_type;

   // clamp a wide signed value to the sample range
   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [WIDE_BITS-1:0] x);
      logic signed [SAMPLE_BITS-1:0] r;
      begin
         if (x > WIDE_HI) begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         end else if (x < WIDE_LO) begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         end else begin
            r = x[SAMPLE_BITS-1:0];
         end
         return r;
      end
   endfunction

endpackage

>>> rtl/core/stereo_ping_pong_delay_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo ping-pong delay unit
// Feedback delay with a one-pole damping filter in the loop, optional crossing
// of the feedback between channels, and a dry/wet output mix.
// ----------------------------------------------------------------------------
//
//   channel  ports                               direction  carries
//   req      req_valid req_ready req_item        in         stereo input pair
//   rsp      rsp_valid rsp_ready rsp_item        out        mixed output pair
//   csr      csr_valid csr_ready csr_index/data  in         register writes
//
// An enabled item steps through memory read, tone product, level update,
// feedback product and write-back, where its result is registered; a bypassed
// item goes from acceptance straight to write-back. The next item can enter
// once write-back is done, so one item is in flight at a time.
// After reset a clearing pass zeroes both delay memories, one entry per
// cycle; no item is accepted meanwhile, registers are.
// The result register lets a new item enter while the last result waits; the
// write-back stage holds while that register is still full.
//
module stereo_ping_pong_delay_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sppd_pkg::req_item_type                req_item,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sppd_pkg::rsp_item_type                rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sppd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sppd_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import sppd_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_TONE,
      S_LEVEL,
      S_FEED,
      S_DONE
   } state_type;

   // configuration registers
   logic                  enabled_ff;
   logic                  mono_ff;
   logic                  ping_pong_ff;
   logic [DELAY_BITS-1:0] delay_ff;
   logic [COEF_BITS-1:0]  gain_ff;
   logic [COEF_BITS-1:0]  wet_ff;
   logic [COEF_BITS-1:0]  alpha_ff;

   // control
   state_type             state_ff;
   logic [ADDR_BITS-1:0]  clr_ff;
   logic [ADDR_BITS-1:0]  wp_ff;
   logic                  bypass_ff;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_item_ff;

   // delay memories and their read data
   logic signed [SAMPLE_BITS-1:0] left_mem  [MAX_DELAY];
   logic signed [SAMPLE_BITS-1:0] right_mem [MAX_DELAY];
   logic signed [SAMPLE_BITS-1:0] left_q_ff;
   logic signed [SAMPLE_BITS-1:0] right_q_ff;

   // datapath registers
   logic signed [SAMPLE_BITS-1:0] in_l_ff, in_r_ff;
   logic signed [LEVEL_BITS-1:0]  level_l_ff, level_r_ff;
   logic signed [TPROD_BITS-1:0]  tprod_l_ff, tprod_r_ff;
   logic signed [WPROD_BITS-1:0]  wprod_l_ff, wprod_r_ff;
   logic signed [DPROD_BITS-1:0]  dprod_l_ff, dprod_r_ff;
   logic signed [FPROD_BITS-1:0]  fprod_l_ff, fprod_r_ff;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_r_ff;

   // combinational signals
   logic                          accept;
   logic                          clearing;
   logic                          out_free;
   logic                          rd_en;
   logic                          we_l, we_r;
   logic [DELAY_BITS-1:0]         delay_eff;
   logic [ADDR_BITS-1:0]          rd_addr;
   logic [ADDR_BITS-1:0]          waddr;
   logic signed [SAMPLE_BITS-1:0] wdata_l, wdata_r;
   logic signed [SAMPLE_BITS-1:0] in_r_sel;
   logic signed [SAMPLE_BITS-1:0] dl, dr;
   logic signed [COEF_BITS:0]     alpha_s, wet_s, gain_s;
   logic [COEF_BITS+1:0]          dry_u;
   logic signed [COEF_BITS+1:0]   dry_s;
   logic signed [DIFF_BITS-1:0]   diff_l, diff_r;
   logic signed [TPROD_BITS-1:0]  tprod_l_in, tprod_r_in;
   logic signed [WPROD_BITS-1:0]  wprod_l_in, wprod_r_in;
   logic signed [DPROD_BITS-1:0]  dprod_l_in, dprod_r_in;
   logic signed [STEP_BITS-1:0]   lsum_l, lsum_r;
   logic signed [LEVEL_BITS-1:0]  level_l_in, level_r_in;
   logic signed [LEVEL_BITS-1:0]  lev_sel_l, lev_sel_r;
   logic signed [FPROD_BITS-1:0]  fprod_l_in, fprod_r_in;
   logic signed [MIX_BITS-1:0]    mix_l, mix_r;
   logic signed [SAMPLE_BITS-1:0] out_l_in, out_r_in;
   logic signed [FB_BITS-1:0]     fb_l, fb_r;
   logic signed [WIDE_BITS-1:0]   wsum_l, wsum_r;

   // handshakes
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign clearing  = (state_ff == S_CLEAR);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= RST_ENABLED;
         mono_ff      <= RST_MONO_MODE;
         ping_pong_ff <= RST_PING_PONG;
         delay_ff     <= RST_DELAY;
         gain_ff      <= RST_GAIN;
         wet_ff       <= RST_WET;
         alpha_ff     <= RST_ALPHA;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLED:       enabled_ff   <= csr_data[0];
            CSR_MONO_MODE:     mono_ff      <= csr_data[0];
            CSR_PING_PONG:     ping_pong_ff <= csr_data[0];
            CSR_DELAY_LENGTH:  delay_ff     <= csr_data[DELAY_BITS-1:0];
            CSR_FEEDBACK_GAIN: gain_ff      <= csr_data[COEF_BITS-1:0];
            CSR_WET_MIX:       wet_ff       <= csr_data[COEF_BITS-1:0];
            CSR_TONE_ALPHA:    alpha_ff     <= csr_data[COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read address: zero delay acts as one; the address wraps modulo the depth
   assign delay_eff = (delay_ff == '0) ? DELAY_BITS'(1) : delay_ff;
   assign rd_addr   = wp_ff - delay_eff[ADDR_BITS-1:0];
   assign rd_en     = accept && enabled_ff;

   // mono: right follows left
   assign in_r_sel = mono_ff ? req_item.left_in : req_item.right_in;
   assign dl       = left_q_ff;
   assign dr       = mono_ff ? left_q_ff : right_q_ff;

   // coefficients as signed operands
   assign alpha_s = $signed({1'b0, alpha_ff});
   assign wet_s   = $signed({1'b0, wet_ff});
   assign gain_s  = $signed({1'b0, (gain_ff > GAIN_CAP) ? GAIN_CAP : gain_ff});
   assign dry_u   = {2'b01, {COEF_BITS{1'b0}}} - {2'b00, wet_ff};
   assign dry_s   = $signed(dry_u);

   // tone filter step and wet product
   assign diff_l = DIFF_BITS'($signed({dl, {TONE_GUARD{1'b0}}})) - DIFF_BITS'(level_l_ff);
   assign diff_r = DIFF_BITS'($signed({dr, {TONE_GUARD{1'b0}}})) - DIFF_BITS'(level_r_ff);
   assign tprod_l_in = diff_l * alpha_s;
   assign tprod_r_in = diff_r * alpha_s;
   assign wprod_l_in = dl * wet_s;
   assign wprod_r_in = dr * wet_s;

   // level update and dry product
   assign lsum_l = STEP_BITS'(level_l_ff) + $signed(tprod_l_ff[TPROD_BITS-1:COEF_BITS]);
   assign lsum_r = STEP_BITS'(level_r_ff) + $signed(tprod_r_ff[TPROD_BITS-1:COEF_BITS]);
   assign level_l_in = lsum_l[LEVEL_BITS-1:0];
   assign level_r_in = lsum_r[LEVEL_BITS-1:0];
   assign dprod_l_in = in_l_ff * dry_s;
   assign dprod_r_in = in_r_ff * dry_s;

   // feedback product with optional crossing, and output mix
   assign lev_sel_l  = ping_pong_ff ? level_r_ff : level_l_ff;
   assign lev_sel_r  = ping_pong_ff ? level_l_ff : level_r_ff;
   assign fprod_l_in = lev_sel_l * gain_s + FB_ROUND;
   assign fprod_r_in = lev_sel_r * gain_s + FB_ROUND;
   assign mix_l = MIX_BITS'(dprod_l_ff) + MIX_BITS'(wprod_l_ff) + MIX_ROUND;
   assign mix_r = MIX_BITS'(dprod_r_ff) + MIX_BITS'(wprod_r_ff) + MIX_ROUND;
   assign out_l_in = sat_sample($signed(mix_l[MIX_BITS-1:COEF_BITS]));
   assign out_r_in = sat_sample($signed(mix_r[MIX_BITS-1:COEF_BITS]));

   // write-back value: input plus rounded feedback, saturated
   assign fb_l   = $signed(fprod_l_ff[FPROD_BITS-1:FB_SHIFT]);
   assign fb_r   = $signed(fprod_r_ff[FPROD_BITS-1:FB_SHIFT]);
   assign wsum_l = WIDE_BITS'(in_l_ff) + WIDE_BITS'(fb_l);
   assign wsum_r = WIDE_BITS'(in_r_ff) + WIDE_BITS'(fb_r);

   // memory write port: clearing pass or item write-back
   assign we_l    = clearing || (state_ff == S_DONE && !bypass_ff && out_free);
   assign we_r    = clearing || (state_ff == S_DONE && !bypass_ff && out_free && !mono_ff);
   assign waddr   = clearing ? clr_ff : wp_ff;
   assign wdata_l = clearing ? '0 : sat_sample(wsum_l);
   assign wdata_r = clearing ? '0 : sat_sample(wsum_r);

   // delay memories, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we_l) begin
         left_mem[waddr] <= wdata_l;
      end
      if (we_r) begin
         right_mem[waddr] <= wdata_r;
      end
      if (rd_en) begin
         left_q_ff  <= left_mem[rd_addr];
         right_q_ff <= right_mem[rd_addr];
      end
   end

   // sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         level_l_ff   <= '0;
         level_r_ff   <= '0;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result taken with no new one loaded behind it
         if (rsp_valid_ff && rsp_ready && !(state_ff == S_DONE && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == {ADDR_BITS{1'b1}}) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  in_l_ff   <= req_item.left_in;
                  in_r_ff   <= in_r_sel;
                  bypass_ff <= !enabled_ff;
                  out_l_ff  <= req_item.left_in;
                  out_r_ff  <= in_r_sel;
                  state_ff  <= enabled_ff ? S_TONE : S_DONE;
               end
            end
            S_TONE: begin
               tprod_l_ff <= tprod_l_in;
               tprod_r_ff <= tprod_r_in;
               wprod_l_ff <= wprod_l_in;
               wprod_r_ff <= wprod_r_in;
               state_ff   <= S_LEVEL;
            end
            S_LEVEL: begin
               level_l_ff <= level_l_in;
               level_r_ff <= level_r_in;
               dprod_l_ff <= dprod_l_in;
               dprod_r_ff <= dprod_r_in;
               state_ff   <= S_FEED;
            end
            S_FEED: begin
               fprod_l_ff <= fprod_l_in;
               fprod_r_ff <= fprod_r_in;
               out_l_ff   <= out_l_in;
               out_r_ff   <= out_r_in;
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_item_ff.left_out  <= out_l_ff;
                  rsp_item_ff.right_out <= out_r_ff;
                  if (!bypass_ff) begin
                     wp_ff <= wp_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // write position only ever steps by one
   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(wp_ff)) |-> (wp_ff == $past(wp_ff) + 1'b1))
      else $error("write position jumped");

   // a result appears only out of the write-back stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside write-back");

   // nothing reaches the output while the memories are being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!rsp_valid_ff && wp_ff == '0))
      else $error("activity during clearing pass");

   // no memory write happens in the same cycle as a memory read
   a_port_split: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !(we_l || we_r))
      else $error("memory read and write overlap");
`endif

endmodule
